// ----- src/jte_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the token emitter
package jte_pkg;

   // nesting stack size and index width
   localparam int MAX_DEPTH  = 128;
   localparam int DEPTH_W    = $clog2(MAX_DEPTH);
   // decimal digits needed for the magnitude of a 64-bit signed value
   localparam int NUM_DIGITS = 19;
   localparam int DIGIT_W    = $clog2(NUM_DIGITS);
   localparam int NUM_W      = 64;
   localparam int STEP_W     = $clog2(NUM_W);
   // longest byte run for one non-integer token
   localparam int BUF_LEN    = 6;
   localparam int BUF_W      = $clog2(BUF_LEN + 1);

   // token operation codes
   localparam logic [3:0] OP_START      = 4'd0;
   localparam logic [3:0] OP_INT        = 4'd1;
   localparam logic [3:0] OP_LITERAL    = 4'd2;
   localparam logic [3:0] OP_STR_BEGIN  = 4'd3;
   localparam logic [3:0] OP_STR_BYTE   = 4'd4;
   localparam logic [3:0] OP_STR_END    = 4'd5;
   localparam logic [3:0] OP_OPEN_OBJ   = 4'd6;
   localparam logic [3:0] OP_OPEN_ARR   = 4'd7;
   localparam logic [3:0] OP_CLOSE      = 4'd8;

   // literal kinds
   localparam logic [1:0] LIT_TRUE  = 2'd0;
   localparam logic [1:0] LIT_FALSE = 2'd1;

   // per-level states
   localparam logic [2:0] LV_START     = 3'd0;
   localparam logic [2:0] LV_MAP_START = 3'd1;
   localparam logic [2:0] LV_MAP_KEY   = 3'd2;
   localparam logic [2:0] LV_MAP_VAL   = 3'd3;
   localparam logic [2:0] LV_ARR_START = 3'd4;
   localparam logic [2:0] LV_IN_ARR    = 3'd5;
   localparam logic [2:0] LV_COMPLETE  = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_KEY_STRING  = 3'd1;
   localparam logic [2:0] ST_DEPTH       = 3'd2;
   localparam logic [2:0] ST_BAD_CLOSE   = 3'd3;
   localparam logic [2:0] ST_AFTER_DONE  = 3'd4;
   localparam logic [2:0] ST_STR_ORDER   = 3'd5;

   // controller states
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EVAL = 6'b000010,
      S_CONV = 6'b000100,
      S_POP  = 6'b001000,
      S_EMIT = 6'b010000,
      S_DIG  = 6'b100000
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic eval;
      logic conv_step;
      logic pop;
      logic emit_buf;
      logic emit_mark;
      logic skip_dig;
      logic emit_dig;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic num_go;
      logic pop_go;
      logic conv_done;
      logic buf_empty;
      logic buf_final;
      logic num_mode;
      logic dig_skip;
      logic dig_last;
      logic out_ready;
   } sts_type;

endpackage

// ----- src/jte_ctrl.sv -----
// sequencing state machine of the token emitter
module jte_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  jte_pkg::sts_type sts,
   output jte_pkg::cmd_type cmd
);

   jte_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jte_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         jte_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = jte_pkg::S_EVAL;
            end
         end
         jte_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.num_go) begin
               state_in = jte_pkg::S_CONV;
            end else if (sts.pop_go) begin
               state_in = jte_pkg::S_POP;
            end else begin
               state_in = jte_pkg::S_EMIT;
            end
         end
         jte_pkg::S_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_done) begin
               state_in = jte_pkg::S_EMIT;
            end
         end
         jte_pkg::S_POP: begin
            cmd.pop  = 1'b1;
            state_in = jte_pkg::S_EMIT;
         end
         jte_pkg::S_EMIT: begin
            if (sts.buf_empty) begin
               if (sts.num_mode) begin
                  state_in = jte_pkg::S_DIG;
               end else if (sts.out_ready) begin
                  cmd.emit_mark = 1'b1;
                  state_in      = jte_pkg::S_IDLE;
               end
            end else if (sts.out_ready) begin
               cmd.emit_buf = 1'b1;
               if (sts.buf_final && !sts.num_mode) begin
                  state_in = jte_pkg::S_IDLE;
               end
            end
         end
         jte_pkg::S_DIG: begin
            if (sts.dig_skip) begin
               cmd.skip_dig = 1'b1;
            end else if (sts.out_ready) begin
               cmd.emit_dig = 1'b1;
               if (sts.dig_last) begin
                  state_in = jte_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = jte_pkg::S_IDLE;
         end
      endcase
   end

   // input side takes a transfer only when idle
   assign req_stall = (state_ff != jte_pkg::S_IDLE);

endmodule

// ----- src/jte_datapath.sv -----
// item registers, level stack, byte buffer, decimal converter and result register
module jte_datapath (
   input  logic             clock,
   input  logic             reset,
   input  logic [3:0]       req_operation,
   input  logic [63:0]      req_number_value,
   input  logic [7:0]       req_data_byte,
   input  logic [1:0]       req_literal_kind,
   input  jte_pkg::cmd_type cmd,
   output jte_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last_of_item,
   output logic [2:0]       rsp_status
);

   // hex digit character
   function automatic logic [7:0] hex_chr(input logic [3:0] d);
      hex_chr = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h37 + {4'd0, d});
   endfunction

   // level state after a value completes
   function automatic logic [2:0] advance(input logic [2:0] s);
      case (s)
         jte_pkg::LV_START:     advance = jte_pkg::LV_COMPLETE;
         jte_pkg::LV_MAP_START: advance = jte_pkg::LV_MAP_VAL;
         jte_pkg::LV_MAP_KEY:   advance = jte_pkg::LV_MAP_VAL;
         jte_pkg::LV_ARR_START: advance = jte_pkg::LV_IN_ARR;
         jte_pkg::LV_MAP_VAL:   advance = jte_pkg::LV_MAP_KEY;
         default:               advance = s;
      endcase
   endfunction

   // latched item
   logic [3:0]  op_ff;
   logic [63:0] num_ff;
   logic [7:0]  byte_ff;
   logic [1:0]  kind_ff;

   // document state
   logic [2:0]                   top_ff;
   logic [jte_pkg::DEPTH_W-1:0]  depth_ff;
   logic                         instr_ff;
   logic                         err_ff;
   logic [2:0]                   code_ff;

   // saved level states below the top
   logic [2:0] stk_mem [jte_pkg::MAX_DEPTH];
   logic [2:0] rd_ff;
   logic       mem_we;

   // byte buffer and marker
   logic [7:0]                  buf_ff [jte_pkg::BUF_LEN];
   logic [jte_pkg::BUF_W-1:0]   cnt_ff;
   logic [2:0]                  mark_ff;

   // decimal conversion
   logic                         num_mode_ff;
   logic [jte_pkg::NUM_W-1:0]    bin_ff;
   logic [3:0]                   bcd_ff [jte_pkg::NUM_DIGITS];
   logic [3:0]                   adj    [jte_pkg::NUM_DIGITS];
   logic [jte_pkg::STEP_W-1:0]   ctr_ff;
   logic [jte_pkg::DIGIT_W-1:0]  dptr_ff;
   logic                         started_ff;
   logic [3:0]                   dig_cur;

   // result register
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_bv_ff;
   logic       out_last_ff;
   logic [2:0] out_st_ff;
   logic       out_ready;

   // evaluation of the latched token
   logic [2:0]                err;
   logic [7:0]                body   [jte_pkg::BUF_LEN];
   logic [jte_pkg::BUF_W-1:0] blen;
   logic [7:0]                buf_new [jte_pkg::BUF_LEN];
   logic [jte_pkg::BUF_W-1:0] len_new;
   logic                      use_sep;
   logic                      key_wait;
   logic                      ok_go;
   logic [jte_pkg::NUM_W-1:0] mag;

   always_comb begin
      err      = jte_pkg::ST_OK;
      blen     = '0;
      use_sep  = 1'b0;
      key_wait = (top_ff == jte_pkg::LV_MAP_START) || (top_ff == jte_pkg::LV_MAP_KEY);
      for (int i = 0; i < jte_pkg::BUF_LEN; i++) begin
         body[i] = 8'h00;
      end
      case (op_ff)
         jte_pkg::OP_INT, jte_pkg::OP_LITERAL, jte_pkg::OP_STR_BEGIN,
         jte_pkg::OP_OPEN_OBJ, jte_pkg::OP_OPEN_ARR: begin
            if (instr_ff) begin
               err = jte_pkg::ST_STR_ORDER;
            end else if (top_ff == jte_pkg::LV_COMPLETE) begin
               err = jte_pkg::ST_AFTER_DONE;
            end else if (key_wait && op_ff != jte_pkg::OP_STR_BEGIN) begin
               err = jte_pkg::ST_KEY_STRING;
            end else if ((op_ff == jte_pkg::OP_OPEN_OBJ || op_ff == jte_pkg::OP_OPEN_ARR)
                         && depth_ff == jte_pkg::DEPTH_W'(jte_pkg::MAX_DEPTH - 1)) begin
               err = jte_pkg::ST_DEPTH;
            end
            use_sep = (top_ff == jte_pkg::LV_MAP_KEY) || (top_ff == jte_pkg::LV_IN_ARR)
                      || (top_ff == jte_pkg::LV_MAP_VAL);
            case (op_ff)
               jte_pkg::OP_INT: begin
                  if (num_ff[63]) begin
                     body[0] = 8'h2D;
                     blen    = jte_pkg::BUF_W'(1);
                  end
               end
               jte_pkg::OP_LITERAL: begin
                  case (kind_ff)
                     jte_pkg::LIT_TRUE: begin
                        body[0] = 8'h74; body[1] = 8'h72; body[2] = 8'h75; body[3] = 8'h65;
                        blen = jte_pkg::BUF_W'(4);
                     end
                     jte_pkg::LIT_FALSE: begin
                        body[0] = 8'h66; body[1] = 8'h61; body[2] = 8'h6C; body[3] = 8'h73;
                        body[4] = 8'h65;
                        blen = jte_pkg::BUF_W'(5);
                     end
                     default: begin
                        body[0] = 8'h6E; body[1] = 8'h75; body[2] = 8'h6C; body[3] = 8'h6C;
                        blen = jte_pkg::BUF_W'(4);
                     end
                  endcase
               end
               jte_pkg::OP_STR_BEGIN: begin
                  body[0] = 8'h22;
                  blen    = jte_pkg::BUF_W'(1);
               end
               jte_pkg::OP_OPEN_OBJ: begin
                  body[0] = 8'h7B;
                  blen    = jte_pkg::BUF_W'(1);
               end
               default: begin
                  body[0] = 8'h5B;
                  blen    = jte_pkg::BUF_W'(1);
               end
            endcase
         end
         jte_pkg::OP_STR_BYTE: begin
            if (!instr_ff) begin
               err = jte_pkg::ST_STR_ORDER;
            end
            body[0] = 8'h5C;
            blen    = jte_pkg::BUF_W'(2);
            case (byte_ff)
               8'h0D:   body[1] = 8'h72;
               8'h0A:   body[1] = 8'h6E;
               8'h5C:   body[1] = 8'h5C;
               8'h22:   body[1] = 8'h22;
               8'h0C:   body[1] = 8'h66;
               8'h08:   body[1] = 8'h62;
               8'h09:   body[1] = 8'h74;
               default: begin
                  if (byte_ff < 8'd32) begin
                     body[1] = 8'h75; body[2] = 8'h30; body[3] = 8'h30;
                     body[4] = hex_chr(byte_ff[7:4]);
                     body[5] = hex_chr(byte_ff[3:0]);
                     blen    = jte_pkg::BUF_W'(6);
                  end else begin
                     body[0] = byte_ff;
                     blen    = jte_pkg::BUF_W'(1);
                  end
               end
            endcase
         end
         jte_pkg::OP_STR_END: begin
            if (!instr_ff) begin
               err = jte_pkg::ST_STR_ORDER;
            end
            body[0] = 8'h22;
            blen    = jte_pkg::BUF_W'(1);
         end
         jte_pkg::OP_CLOSE: begin
            blen = jte_pkg::BUF_W'(1);
            if (instr_ff) begin
               err = jte_pkg::ST_STR_ORDER;
            end else if (depth_ff == '0) begin
               err = jte_pkg::ST_BAD_CLOSE;
            end else if (key_wait) begin
               body[0] = 8'h7D;
            end else if (top_ff == jte_pkg::LV_ARR_START || top_ff == jte_pkg::LV_IN_ARR) begin
               body[0] = 8'h5D;
            end else begin
               err = jte_pkg::ST_BAD_CLOSE;
            end
         end
         default: begin
         end
      endcase
      // separator goes in front of the body
      if (use_sep) begin
         buf_new[0] = (top_ff == jte_pkg::LV_MAP_VAL) ? 8'h3A : 8'h2C;
         for (int i = 1; i < jte_pkg::BUF_LEN; i++) begin
            buf_new[i] = body[i-1];
         end
         len_new = blen + jte_pkg::BUF_W'(1);
      end else begin
         for (int i = 0; i < jte_pkg::BUF_LEN; i++) begin
            buf_new[i] = body[i];
         end
         len_new = blen;
      end
   end

   assign ok_go = (op_ff != jte_pkg::OP_START) && !err_ff && (err == jte_pkg::ST_OK);
   assign mag   = num_ff[63] ? (64'd0 - num_ff) : num_ff;

   // level stack memory, one write and one registered read
   assign mem_we = cmd.eval && ok_go
                   && (op_ff == jte_pkg::OP_OPEN_OBJ || op_ff == jte_pkg::OP_OPEN_ARR);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stk_mem[depth_ff] <= top_ff;
      end
      rd_ff <= stk_mem[depth_ff - 1'b1];
   end

   // item capture on an input transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         num_ff  <= req_number_value;
         byte_ff <= req_data_byte;
         kind_ff <= req_literal_kind;
      end
   end

   // document state and buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff      <= jte_pkg::LV_START;
         depth_ff    <= '0;
         instr_ff    <= 1'b0;
         err_ff      <= 1'b0;
         code_ff     <= jte_pkg::ST_OK;
         cnt_ff      <= '0;
         mark_ff     <= jte_pkg::ST_OK;
         num_mode_ff <= 1'b0;
      end else if (cmd.eval) begin
         num_mode_ff <= 1'b0;
         cnt_ff      <= '0;
         mark_ff     <= jte_pkg::ST_OK;
         if (op_ff == jte_pkg::OP_START) begin
            top_ff   <= jte_pkg::LV_START;
            depth_ff <= '0;
            instr_ff <= 1'b0;
            err_ff   <= 1'b0;
            code_ff  <= jte_pkg::ST_OK;
         end else if (err_ff) begin
            mark_ff <= code_ff;
         end else if (err != jte_pkg::ST_OK) begin
            err_ff  <= 1'b1;
            code_ff <= err;
            mark_ff <= err;
         end else begin
            cnt_ff      <= len_new;
            num_mode_ff <= (op_ff == jte_pkg::OP_INT);
            case (op_ff)
               jte_pkg::OP_INT, jte_pkg::OP_LITERAL: top_ff <= advance(top_ff);
               jte_pkg::OP_STR_BEGIN: instr_ff <= 1'b1;
               jte_pkg::OP_STR_END: begin
                  instr_ff <= 1'b0;
                  top_ff   <= advance(top_ff);
               end
               jte_pkg::OP_OPEN_OBJ: begin
                  depth_ff <= depth_ff + 1'b1;
                  top_ff   <= jte_pkg::LV_MAP_START;
               end
               jte_pkg::OP_OPEN_ARR: begin
                  depth_ff <= depth_ff + 1'b1;
                  top_ff   <= jte_pkg::LV_ARR_START;
               end
               default: begin
               end
            endcase
         end
      end else if (cmd.pop) begin
         top_ff   <= advance(rd_ff);
         depth_ff <= depth_ff - 1'b1;
      end else if (cmd.emit_buf) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // buffer contents shift toward the head as bytes go out
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         buf_ff <= buf_new;
      end else if (cmd.emit_buf) begin
         for (int i = 0; i < jte_pkg::BUF_LEN - 1; i++) begin
            buf_ff[i] <= buf_ff[i+1];
         end
      end
   end

   // shift-and-add-three binary to decimal
   always_comb begin
      for (int k = 0; k < jte_pkg::NUM_DIGITS; k++) begin
         adj[k] = (bcd_ff[k] >= 4'd5) ? (bcd_ff[k] + 4'd3) : bcd_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         bin_ff     <= mag;
         ctr_ff     <= '0;
         dptr_ff    <= jte_pkg::DIGIT_W'(jte_pkg::NUM_DIGITS - 1);
         started_ff <= 1'b0;
         for (int k = 0; k < jte_pkg::NUM_DIGITS; k++) begin
            bcd_ff[k] <= 4'd0;
         end
      end else if (cmd.conv_step) begin
         bin_ff <= {bin_ff[jte_pkg::NUM_W-2:0], 1'b0};
         ctr_ff <= ctr_ff + 1'b1;
         bcd_ff[0] <= {adj[0][2:0], bin_ff[jte_pkg::NUM_W-1]};
         for (int k = 1; k < jte_pkg::NUM_DIGITS; k++) begin
            bcd_ff[k] <= {adj[k][2:0], adj[k-1][3]};
         end
      end else if (cmd.skip_dig || cmd.emit_dig) begin
         dptr_ff    <= dptr_ff - 1'b1;
         started_ff <= started_ff | cmd.emit_dig;
      end
   end

   assign dig_cur = bcd_ff[dptr_ff];

   // result register
   assign out_ready = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_buf || cmd.emit_mark || cmd.emit_dig) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_buf) begin
         out_byte_ff <= buf_ff[0];
         out_bv_ff   <= 1'b1;
         out_last_ff <= (cnt_ff == jte_pkg::BUF_W'(1)) && !num_mode_ff;
         out_st_ff   <= jte_pkg::ST_OK;
      end else if (cmd.emit_mark) begin
         out_byte_ff <= 8'h00;
         out_bv_ff   <= 1'b0;
         out_last_ff <= 1'b1;
         out_st_ff   <= mark_ff;
      end else if (cmd.emit_dig) begin
         out_byte_ff <= {4'h3, dig_cur};
         out_bv_ff   <= 1'b1;
         out_last_ff <= (dptr_ff == '0);
         out_st_ff   <= jte_pkg::ST_OK;
      end
   end

   // status toward the controller
   always_comb begin
      sts.num_go    = ok_go && (op_ff == jte_pkg::OP_INT);
      sts.pop_go    = ok_go && (op_ff == jte_pkg::OP_CLOSE);
      sts.conv_done = (ctr_ff == jte_pkg::STEP_W'(jte_pkg::NUM_W - 1));
      sts.buf_empty = (cnt_ff == '0);
      sts.buf_final = (cnt_ff == jte_pkg::BUF_W'(1));
      sts.num_mode  = num_mode_ff;
      sts.dig_skip  = !started_ff && (dig_cur == 4'd0) && (dptr_ff != '0);
      sts.dig_last  = (dptr_ff == '0);
      sts.out_ready = out_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = out_bv_ff;
   assign rsp_last_of_item = out_last_ff;
   assign rsp_status       = out_st_ff;

endmodule

// ----- src/json_token_emitter.sv -----
// top level of the JSON token emitter
//
// Tokens arrive on the req_ channel (operation, number, string byte, literal
// kind) and JSON text leaves on the rsp_ channel, one byte per transfer, with
// rsp_last_of_item on the final transfer of each token. A token that makes no
// text (start document, an error, an unknown code) gives one marker transfer
// with rsp_byte_valid low and the status code. Errors stay latched until the
// next start-document token.
// One token is worked at a time: req_stall is high from the transfer until
// its last result is loaded into the output register. A token passes the
// load and evaluate states, a close also the pop state (level stack memory
// read), then its output bytes leave one per cycle while the receiver does
// not stall. An integer runs a shift-and-add-three conversion over all 64
// bits of its magnitude, sends its separator and sign bytes, then walks the
// 19 digit positions and skips leading zeros.
// Reset returns to an empty document with no error; the stack memory needs no
// clearing pass. While the receiver stalls, the held result stays on the
// rsp_ ports and the sequencer waits before loading its next result.
module json_token_emitter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [63:0] req_number_value,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_literal_kind,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_item,
   output logic [2:0]  rsp_status
);

   jte_pkg::cmd_type cmd;
   jte_pkg::sts_type sts;

   // sequencer
   jte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   jte_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_number_value (req_number_value),
      .req_data_byte    (req_data_byte),
      .req_literal_kind (req_literal_kind),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_status       (rsp_status)
   );

endmodule
